@@ design/json_token_serializer_assert.svh @@
// ----------------------------------------------------------------------------
// json_token_serializer_assert.svh
// Assertion macros used by the serializer checker.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_SERIALIZER_ASSERT_SVH
`define JSON_TOKEN_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define JTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serializer check failed");

// next-cycle implication
`define JTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serializer check failed");

`endif

@@ design/jts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg
// Types, codes and character constants of the JSON token serializer.
// ----------------------------------------------------------------------------
package jts_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int MAX_BYTES   = 6;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);
	localparam int IDX_W       = $clog2(MAX_BYTES);

	typedef logic [7:0] octet_t;

	typedef enum logic [2:0] {
		CMD_BEGIN_OBJ = 3'd0,
		CMD_BEGIN_ARR = 3'd1,
		CMD_END       = 3'd2,
		CMD_STR_OPEN  = 3'd3,
		CMD_STR_BYTE  = 3'd4,
		CMD_STR_CLOSE = 3'd5,
		CMD_BOOL      = 3'd6,
		CMD_NULL      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		NEST_NONE     = 3'd0,
		NEST_VALUE    = 3'd1,
		NEST_OBJ      = 3'd2,
		NEST_KEY      = 3'd3,
		NEST_OBJ_CONT = 3'd4,
		NEST_ARR      = 3'd5,
		NEST_ARR_CONT = 3'd6
	} nest_t;

	typedef struct packed {
		octet_t [MAX_BYTES-1:0] bytes;
		logic [CNT_W-1:0]       count;
		logic                   error;
		logic                   complete;
	} result_t;

	localparam octet_t CH_LBRACE    = 8'h7B;
	localparam octet_t CH_RBRACE    = 8'h7D;
	localparam octet_t CH_LBRACKET  = 8'h5B;
	localparam octet_t CH_RBRACKET  = 8'h5D;
	localparam octet_t CH_COLON     = 8'h3A;
	localparam octet_t CH_COMMA     = 8'h2C;
	localparam octet_t CH_QUOTE     = 8'h22;
	localparam octet_t CH_BACKSLASH = 8'h5C;
	localparam octet_t CH_SLASH     = 8'h2F;
	localparam octet_t CH_BS        = 8'h08;
	localparam octet_t CH_FF        = 8'h0C;
	localparam octet_t CH_LF        = 8'h0A;
	localparam octet_t CH_CR        = 8'h0D;
	localparam octet_t CH_TAB       = 8'h09;
	localparam octet_t CH_A         = 8'h61;
	localparam octet_t CH_B         = 8'h62;
	localparam octet_t CH_E         = 8'h65;
	localparam octet_t CH_F         = 8'h66;
	localparam octet_t CH_L         = 8'h6C;
	localparam octet_t CH_N         = 8'h6E;
	localparam octet_t CH_R         = 8'h72;
	localparam octet_t CH_S         = 8'h73;
	localparam octet_t CH_T         = 8'h74;
	localparam octet_t CH_U         = 8'h75;

endpackage

@@ design/jts_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_core
// Nesting stack, string and error state; turns one event into its bytes.
// ----------------------------------------------------------------------------
module jts_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  jts_pkg::cmd_t    cmd,
	input  logic [7:0]       data_byte,
	input  logic             bool_value,
	output jts_pkg::result_t result
);

	jts_pkg::nest_t                 stack_q [jts_pkg::STACK_DEPTH];
	logic [jts_pkg::LEVEL_W-1:0]    level_q;
	logic                           error_q;
	logic                           in_str_q;

	logic [jts_pkg::LEVEL_W-1:0]    lvl_m1;
	logic [jts_pkg::LEVEL_W-1:0]    lvl_mid;
	logic [jts_pkg::LEVEL_W-1:0]    level_n;
	jts_pkg::nest_t                 top;

	logic                           ev_ok;
	logic                           ev_pop;
	logic                           ev_sep_en;
	jts_pkg::octet_t                ev_sep;
	logic                           ev_wr;
	jts_pkg::nest_t                 ev_val;

	logic                           ok;
	logic                           use_ev;
	logic                           end_pop;
	logic                           push;
	jts_pkg::nest_t                 push_val;
	logic                           str_set;
	logic                           str_clr;
	jts_pkg::octet_t                body [jts_pkg::MAX_BYTES];
	logic [jts_pkg::CNT_W-1:0]      body_n;
	logic                           commit;
	logic                           sep_en;
	logic                           err_n;
	logic                           in_str_n;

	assign lvl_m1 = level_q - jts_pkg::LEVEL_W'(1);
	assign top    = (level_q == '0) ? jts_pkg::NEST_NONE : stack_q[lvl_m1[jts_pkg::PTR_W-1:0]];

	always_comb begin
		ev_ok     = 1'b1;
		ev_pop    = 1'b0;
		ev_sep_en = 1'b0;
		ev_sep    = jts_pkg::CH_COMMA;
		ev_wr     = 1'b0;
		ev_val    = top;
		if (level_q == '0) begin
			ev_ok = 1'b0;
		end else if ((cmd == jts_pkg::CMD_BEGIN_OBJ || cmd == jts_pkg::CMD_BEGIN_ARR) &&
				top != jts_pkg::NEST_VALUE &&
				level_q >= jts_pkg::LEVEL_W'(jts_pkg::STACK_DEPTH)) begin
			ev_ok = 1'b0;
		end else begin
			case (top) inside
				jts_pkg::NEST_VALUE: begin
					ev_pop = 1'b1;
				end
				jts_pkg::NEST_KEY: begin
					ev_sep_en = 1'b1;
					ev_sep    = jts_pkg::CH_COLON;
					ev_wr     = 1'b1;
					ev_val    = jts_pkg::NEST_OBJ_CONT;
				end
				jts_pkg::NEST_ARR: begin
					ev_wr  = 1'b1;
					ev_val = jts_pkg::NEST_ARR_CONT;
				end
				jts_pkg::NEST_ARR_CONT: begin
					ev_sep_en = 1'b1;
				end
				jts_pkg::NEST_OBJ, jts_pkg::NEST_OBJ_CONT: begin
					if (cmd != jts_pkg::CMD_STR_OPEN) begin
						ev_ok = 1'b0;
					end else begin
						ev_sep_en = (top == jts_pkg::NEST_OBJ_CONT);
						ev_wr     = 1'b1;
						ev_val    = jts_pkg::NEST_KEY;
					end
				end
				default: begin
					ev_ok = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		ok       = 1'b1;
		use_ev   = 1'b0;
		end_pop  = 1'b0;
		push     = 1'b0;
		push_val = jts_pkg::NEST_OBJ;
		str_set  = 1'b0;
		str_clr  = 1'b0;
		body_n   = '0;
		for (int i = 0; i < jts_pkg::MAX_BYTES; i++) begin
			body[i] = '0;
		end
		if (in_str_q) begin
			case (cmd)
				jts_pkg::CMD_STR_BYTE: begin
					body[0] = jts_pkg::CH_BACKSLASH;
					body_n  = jts_pkg::CNT_W'(2);
					case (data_byte)
						jts_pkg::CH_BACKSLASH: body[1] = jts_pkg::CH_BACKSLASH;
						jts_pkg::CH_QUOTE:     body[1] = jts_pkg::CH_QUOTE;
						jts_pkg::CH_SLASH:     body[1] = jts_pkg::CH_SLASH;
						jts_pkg::CH_BS:        body[1] = jts_pkg::CH_B;
						jts_pkg::CH_FF:        body[1] = jts_pkg::CH_F;
						jts_pkg::CH_LF:        body[1] = jts_pkg::CH_N;
						jts_pkg::CH_CR:        body[1] = jts_pkg::CH_R;
						jts_pkg::CH_TAB:       body[1] = jts_pkg::CH_T;
						default: begin
							body[0] = data_byte;
							body_n  = jts_pkg::CNT_W'(1);
						end
					endcase
				end
				jts_pkg::CMD_STR_CLOSE: begin
					body[0] = jts_pkg::CH_QUOTE;
					body_n  = jts_pkg::CNT_W'(1);
					str_clr = 1'b1;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end else begin
			case (cmd)
				jts_pkg::CMD_BEGIN_OBJ, jts_pkg::CMD_BEGIN_ARR: begin
					ok       = ev_ok;
					use_ev   = 1'b1;
					push     = 1'b1;
					push_val = (cmd == jts_pkg::CMD_BEGIN_OBJ) ? jts_pkg::NEST_OBJ
						: jts_pkg::NEST_ARR;
					body[0]  = (cmd == jts_pkg::CMD_BEGIN_OBJ) ? jts_pkg::CH_LBRACE
						: jts_pkg::CH_LBRACKET;
					body_n   = jts_pkg::CNT_W'(1);
				end
				jts_pkg::CMD_END: begin
					end_pop = 1'b1;
					body_n  = jts_pkg::CNT_W'(1);
					case (top) inside
						jts_pkg::NEST_OBJ, jts_pkg::NEST_OBJ_CONT: body[0] = jts_pkg::CH_RBRACE;
						jts_pkg::NEST_ARR, jts_pkg::NEST_ARR_CONT: body[0] = jts_pkg::CH_RBRACKET;
						default: ok = 1'b0;
					endcase
				end
				jts_pkg::CMD_STR_OPEN: begin
					ok      = ev_ok;
					use_ev  = 1'b1;
					str_set = 1'b1;
					body[0] = jts_pkg::CH_QUOTE;
					body_n  = jts_pkg::CNT_W'(1);
				end
				jts_pkg::CMD_BOOL: begin
					ok     = ev_ok;
					use_ev = 1'b1;
					if (bool_value) begin
						body[0] = jts_pkg::CH_T;
						body[1] = jts_pkg::CH_R;
						body[2] = jts_pkg::CH_U;
						body[3] = jts_pkg::CH_E;
						body_n  = jts_pkg::CNT_W'(4);
					end else begin
						body[0] = jts_pkg::CH_F;
						body[1] = jts_pkg::CH_A;
						body[2] = jts_pkg::CH_L;
						body[3] = jts_pkg::CH_S;
						body[4] = jts_pkg::CH_E;
						body_n  = jts_pkg::CNT_W'(5);
					end
				end
				jts_pkg::CMD_NULL: begin
					ok      = ev_ok;
					use_ev  = 1'b1;
					body[0] = jts_pkg::CH_N;
					body[1] = jts_pkg::CH_U;
					body[2] = jts_pkg::CH_L;
					body[3] = jts_pkg::CH_L;
					body_n  = jts_pkg::CNT_W'(4);
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	assign commit   = !error_q && ok;
	assign sep_en   = use_ev && ev_sep_en;
	assign lvl_mid  = level_q - jts_pkg::LEVEL_W'((use_ev && ev_pop) || end_pop);
	assign level_n  = commit ? (lvl_mid + jts_pkg::LEVEL_W'(push)) : level_q;
	assign err_n    = error_q || !ok;
	assign in_str_n = commit ? ((in_str_q && !str_clr) || str_set) : in_str_q;

	always_comb begin
		for (int i = 0; i < jts_pkg::MAX_BYTES; i++) begin
			if (!sep_en) begin
				result.bytes[i] = body[i];
			end else if (i == 0) begin
				result.bytes[i] = ev_sep;
			end else begin
				result.bytes[i] = body[i-1];
			end
		end
		result.count    = commit ? (body_n + jts_pkg::CNT_W'(sep_en)) : '0;
		result.error    = err_n;
		result.complete = (level_n == '0) && !in_str_n && !err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jts_pkg::STACK_DEPTH; i++) begin
				stack_q[i] <= (i == 0) ? jts_pkg::NEST_VALUE : jts_pkg::NEST_NONE;
			end
			level_q    <= jts_pkg::LEVEL_W'(1);
			error_q    <= 1'b0;
			in_str_q   <= 1'b0;
		end else if (advance) begin
			level_q  <= level_n;
			error_q  <= err_n;
			in_str_q <= in_str_n;
			if (commit && use_ev && ev_wr) begin
				stack_q[lvl_m1[jts_pkg::PTR_W-1:0]] <= ev_val;
			end
			if (commit && push) begin
				stack_q[lvl_mid[jts_pkg::PTR_W-1:0]] <= push_val;
			end
		end
	end

endmodule

@@ design/jts_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_emitter
// Result register; sends the bytes of one event one transaction at a time.
// ----------------------------------------------------------------------------
module jts_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jts_pkg::result_t load_result,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // out_byte[7:0], error[8], complete[9]
	output logic [0:0]       m_tuser,   // byte_valid[0]
	output logic             m_tlast
);

	jts_pkg::result_t             res_q;
	logic                         valid_q;
	logic [jts_pkg::IDX_W-1:0]    idx_q;
	logic                         has_bytes;
	logic [jts_pkg::IDX_W-1:0]    idx_last;
	jts_pkg::octet_t              out_byte;

	assign has_bytes = (res_q.count != '0);
	assign idx_last  = has_bytes ? jts_pkg::IDX_W'(res_q.count - jts_pkg::CNT_W'(1)) : '0;
	assign out_byte  = has_bytes ? res_q.bytes[idx_q] : '0;

	assign m_tvalid = valid_q;
	assign m_tlast  = (idx_q == idx_last);
	assign m_tuser  = has_bytes;
	assign m_tdata  = {6'b0, res_q.complete, res_q.error, out_byte};
	assign free     = !valid_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_tready) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + jts_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_result;
		end
	end

endmodule

@@ design/json_token_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_serializer
// Streaming JSON text writer driven by structure events.
// ----------------------------------------------------------------------------
// Each event is taken into an input register (one event per cycle when the
// path ahead is free), decoded against the 32-entry nesting stack in one
// pass and stored in a result register, from which its text leaves one byte
// per output transaction: 1 to 6 transactions per event, so the byte-wide
// output port sets the sustained rate. An event that emits nothing, or any
// event after the sticky error is set, yields a single status transaction
// with tuser low. The stack lives in flip-flops and is ready right out of
// reset.
module json_token_serializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // data_byte[7:0], bool_value[8]
	input  logic [2:0]  s_tuser,    // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // out_byte[7:0], error[8], complete[9]
	output logic [0:0]  m_tuser,    // byte_valid[0]
	output logic        m_tlast
);

	jts_pkg::cmd_t    cmd_s1;
	logic [7:0]       data_s1;
	logic             bool_s1;
	logic             valid_s1;
	logic             free;
	logic             advance;
	jts_pkg::result_t result;

	assign advance  = valid_s1 && free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= jts_pkg::cmd_t'(s_tuser);
			data_s1 <= s_tdata[7:0];
			bool_s1 <= s_tdata[8];
		end
	end

	jts_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cmd        (cmd_s1),
		.data_byte  (data_s1),
		.bool_value (bool_s1),
		.result     (result)
	);

	jts_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.load_result (result),
		.free        (free),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

@@ design/jts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks of the serializer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_token_serializer_assert.svh"

module jts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	logic        out_xfer;
	logic        out_err;
	logic        out_done;
	logic [17:0] out_word;

	assign out_xfer = m_tvalid && m_tready;
	assign out_err  = m_tdata[8];
	assign out_done = m_tdata[9];
	assign out_word = {m_tdata, m_tuser, m_tlast};

	`JTS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))
	`JTS_ASSERT_NEXT(a_error_sticky, clk, arst_n, out_xfer && out_err, !m_tvalid || out_err)
	`JTS_ASSERT_NOW(a_status_only, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast && (m_tdata[7:0] == '0))
	`JTS_ASSERT_NOW(a_error_silent, clk, arst_n, m_tvalid && out_err, !m_tuser[0] && !out_done)
	`JTS_ASSERT_NOW(a_ready_when_free, clk, arst_n, !m_tvalid || (out_xfer && m_tlast), s_tready)

endmodule

bind json_token_serializer jts_checker u_jts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
